@@ rtl/clq_pkg.sv @@
`default_nettype none

package clq_pkg;

    // node pool
    localparam int NODE_COUNT = 256;
    localparam int NODE_W     = 8;
    localparam int OPCODE_W   = 3;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INIT   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_POP    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_ROTATE = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_HEAD   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SUCC   = 3'd7;

    // status codes
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_EMPTY = 1'b1;

    // one access to the next-pointer memory
    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        logic [NODE_W-1:0] wdata;
    } t_mem_req;

    // one result item
    typedef struct packed {
        logic              status;
        logic              present;
        logic [NODE_W-1:0] node;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/clq_ram.sv @@
`default_nettype none

module clq_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

@@ rtl/clq_ctrl.sv @@
`default_nettype none

module clq_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_req_valid,
    output logic                                  o_req_ready,
    input  wire logic [clq_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire logic [clq_pkg::NODE_W-1:0]       i_node,
    output clq_pkg::t_mem_req                     o_mem,
    input  wire logic [clq_pkg::NODE_W-1:0]       i_mem_rdata,
    output logic                                  o_res_valid,
    input  wire logic                             i_res_ready,
    output clq_pkg::t_result                      o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;
    localparam logic [2:0] S_RDB   = 3'd3;
    localparam logic [2:0] S_WRB   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                       r_state, n_state;
    logic [clq_pkg::OPCODE_W-1:0]     r_op, n_op;
    logic [clq_pkg::NODE_W-1:0]       r_node, n_node;
    logic [clq_pkg::NODE_W-1:0]       r_head, n_head;
    logic [clq_pkg::NODE_W-1:0]       r_tail, n_tail;
    logic                             r_nonempty, n_nonempty;
    clq_pkg::t_result                 r_res, n_res;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_node     = r_node;
        n_head     = r_head;
        n_tail     = r_tail;
        n_nonempty = r_nonempty;
        n_res      = r_res;
        o_mem      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = i_opcode;
                    n_node  = i_node;
                    n_res   = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DONE;
                unique case (r_op)
                    clq_pkg::OP_CLEAR: begin
                        n_nonempty = 1'b0;
                    end
                    clq_pkg::OP_INIT: begin
                        o_mem = '{we: 1'b1, addr: r_node, wdata: r_node};
                    end
                    clq_pkg::OP_PUSH, clq_pkg::OP_APPEND: begin
                        if (r_nonempty) begin
                            // fetch the head first
                            o_mem.addr = r_tail;
                            n_state    = S_RDA;
                        end else begin
                            // empty queue: singleton
                            o_mem      = '{we: 1'b1, addr: r_node, wdata: r_node};
                            n_tail     = r_node;
                            n_nonempty = 1'b1;
                        end
                    end
                    clq_pkg::OP_POP: begin
                        if (r_nonempty) begin
                            o_mem.addr = r_tail;
                            n_state    = S_RDA;
                        end else begin
                            n_res.status = clq_pkg::STAT_EMPTY;
                        end
                    end
                    clq_pkg::OP_ROTATE, clq_pkg::OP_HEAD: begin
                        if (r_nonempty) begin
                            o_mem.addr = r_tail;
                            n_state    = S_RDA;
                        end
                    end
                    default: begin
                        // successor query
                        if (!r_nonempty) begin
                            n_res.status = clq_pkg::STAT_EMPTY;
                        end else if (r_node != r_tail) begin
                            o_mem.addr = r_node;
                            n_state    = S_RDA;
                        end
                    end
                endcase
            end
            S_RDA: begin
                n_head  = i_mem_rdata;
                n_state = S_DONE;
                unique case (r_op)
                    clq_pkg::OP_PUSH, clq_pkg::OP_APPEND: begin
                        o_mem.addr = r_node;
                        n_state    = S_RDB;
                    end
                    clq_pkg::OP_POP: begin
                        n_res.node    = i_mem_rdata;
                        n_res.present = 1'b1;
                        if (i_mem_rdata == r_tail) begin
                            // last node leaves
                            n_nonempty = 1'b0;
                            o_mem      = '{we: 1'b1, addr: i_mem_rdata, wdata: i_mem_rdata};
                        end else begin
                            o_mem.addr = i_mem_rdata;
                            n_state    = S_RDB;
                        end
                    end
                    clq_pkg::OP_ROTATE: begin
                        n_tail        = i_mem_rdata;
                        n_res.node    = i_mem_rdata;
                        n_res.present = 1'b1;
                    end
                    default: begin
                        // head query or successor query
                        n_res.node    = i_mem_rdata;
                        n_res.present = 1'b1;
                    end
                endcase
            end
            S_RDB: begin
                // tail's next takes the second read value
                o_mem   = '{we: 1'b1, addr: r_tail, wdata: i_mem_rdata};
                n_state = S_WRB;
            end
            S_WRB: begin
                n_state = S_DONE;
                if (r_op == clq_pkg::OP_POP) begin
                    o_mem = '{we: 1'b1, addr: r_head, wdata: r_head};
                end else begin
                    o_mem = '{we: 1'b1, addr: r_node, wdata: r_head};
                    if (r_op == clq_pkg::OP_APPEND) begin
                        n_tail = r_node;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tail     <= '0;
            r_nonempty <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tail     <= n_tail;
            r_nonempty <= n_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_node <= n_node;
        r_head <= n_head;
        r_res  <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ rtl/circular_linked_queue_manager.sv @@
`default_nettype none

// channel   dir  tdata fields (lsb first)                           request
// s_axis    in   opcode[2:0], node_id[10:3], zero fill to 16 bits    one operation
// m_axis    out  result_node[7:0], result_present[8], status[9],     one result
//                zero fill to 16 bits
//
// each request gives exactly one result
// pointer accesses per request: init and push/append into an empty queue
// write one entry; clear, a successor query of the tail and any other
// request on an empty queue touch none; rotate, head and other successor
// queries read one; pop of the last node reads one and writes one; other pop
// and push/append into a nonempty queue read two entries and write two.
// the single-port next-pointer memory takes one access at a time, registered read.
// synchronous active-low reset empties the queue; the pointer memory is not
// cleared, so every node must be initialized before it is linked in
// the result waits in an output register, so a stalled m_axis side holds the
// next request only once it is finished and needs that register

module circular_linked_queue_manager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // opcode[2:0], node_id[10:3]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata    // result_node[7:0], result_present[8], status[9]
);

    clq_pkg::t_mem_req                 w_mem;
    logic [clq_pkg::NODE_W-1:0]        w_rdata;
    logic                              w_res_valid;
    logic                              w_res_ready;
    clq_pkg::t_result                  w_res;

    logic                              r_out_valid;
    clq_pkg::t_result                  r_out;

    // sequencer: one request at a time, read-modify-write on the pointers
    clq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_opcode    (s_axis_tdata[clq_pkg::OPCODE_W-1:0]),
        .i_node      (s_axis_tdata[clq_pkg::OPCODE_W +: clq_pkg::NODE_W]),
        .o_mem       (w_mem),
        .i_mem_rdata (w_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // next-pointer memory, one port, registered read
    clq_ram #(
        .DEPTH  (clq_pkg::NODE_COUNT),
        .DATA_W (clq_pkg::NODE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_addr  (w_mem.addr),
        .i_wdata (w_mem.wdata),
        .o_rdata (w_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.status, r_out.present, r_out.node};

endmodule

`default_nettype wire

@@ tb/clq_checker.sv @@
`timescale 1ns / 100ps

// watches both stream channels of the queue manager, predicts each answer
// from its own copy of the ring and compares field by field
module clq_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,    // opcode[2:0], node_id[10:3]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,    // result_node[7:0], result_present[8], status[9]
    output int               o_owed,
    output int               o_fail_count,
    output int               o_checked,
    output int               o_empty_errors
);

    // shadow of the pointer memory and the tail register
    logic [clq_pkg::NODE_W-1:0] link [clq_pkg::NODE_COUNT];
    logic [clq_pkg::NODE_W-1:0] ring_tail;
    logic                       ring_live;

    clq_pkg::t_result answers_due[$];
    clq_pkg::t_result got;
    clq_pkg::t_result want;
    int               mismatches;
    int               answers_seen;

    assign o_fail_count = mismatches;

    initial begin
        mismatches     = 0;
        answers_seen   = 0;
        o_checked      = 0;
        o_empty_errors = 0;
        o_owed         = 0;
        ring_tail      = '0;
        ring_live      = 1'b0;
        for (int k = 0; k < clq_pkg::NODE_COUNT; k++) link[k] = '0;
    end

    task automatic report_mismatch(input string what);
        $display("queue manager mismatch at answer %0d: %s", answers_seen, what);
        mismatches++;
    endtask

    // applies one request to the shadow ring and gives the answer it owes
    function automatic clq_pkg::t_result apply_queue_op(
            input logic [clq_pkg::OPCODE_W-1:0] op,
            input logic [clq_pkg::NODE_W-1:0]   node);
        clq_pkg::t_result           r;
        logic [clq_pkg::NODE_W-1:0] head;
        logic [clq_pkg::NODE_W-1:0] node_next;
        r = '0;
        case (op)
            clq_pkg::OP_CLEAR: begin
                ring_live = 1'b0;
            end
            clq_pkg::OP_INIT: begin
                link[node] = node;
            end
            clq_pkg::OP_PUSH, clq_pkg::OP_APPEND: begin
                if (ring_live) begin
                    // splice the ring of node in right after the tail
                    head            = link[ring_tail];
                    node_next       = link[node];
                    link[ring_tail] = node_next;
                    link[node]      = head;
                end else begin
                    link[node] = node;
                    ring_tail  = node;
                    ring_live  = 1'b1;
                end
                if (op == clq_pkg::OP_APPEND) ring_tail = node;
            end
            clq_pkg::OP_POP: begin
                if (!ring_live) begin
                    r.status = clq_pkg::STAT_EMPTY;
                end else begin
                    head = link[ring_tail];
                    if (head == ring_tail) ring_live = 1'b0;
                    else link[ring_tail] = link[head];
                    link[head] = head;
                    r.node     = head;
                    r.present  = 1'b1;
                end
            end
            clq_pkg::OP_ROTATE: begin
                if (ring_live) begin
                    ring_tail = link[ring_tail];
                    r.node    = ring_tail;
                    r.present = 1'b1;
                end
            end
            clq_pkg::OP_HEAD: begin
                if (ring_live) begin
                    r.node    = link[ring_tail];
                    r.present = 1'b1;
                end
            end
            clq_pkg::OP_SUCC: begin
                if (!ring_live) begin
                    r.status = clq_pkg::STAT_EMPTY;
                end else if (node != ring_tail) begin
                    r.node    = link[node];
                    r.present = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_live = 1'b0;
            ring_tail = '0;
            answers_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[9:0];
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("answer with no request owed, data %h",
                                              i_m_tdata));
                end else begin
                    want = answers_due.pop_front();
                    if (got.node != want.node)
                        report_mismatch($sformatf("result_node %0d, expected %0d",
                                                  got.node, want.node));
                    if (got.present != want.present)
                        report_mismatch($sformatf("result_present %0d, expected %0d",
                                                  got.present, want.present));
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (want.status == clq_pkg::STAT_EMPTY) o_empty_errors++;
                    o_checked++;
                end
                answers_seen++;
            end
            if (i_s_tvalid && i_s_tready)
                answers_due.push_back(apply_queue_op(i_s_tdata[2:0], i_s_tdata[10:3]));
        end
        o_owed <= answers_due.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// stimulus and verdict for the circular linked queue manager; all answer
// checking lives in clq_checker
module tb;

    localparam int RANDOM_REQUESTS = 950;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // opcode[2:0], node_id[10:3]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // result_node[7:0], result_present[8], status[9]

    int owed;
    int fail_count;
    int checked;
    int empty_errors;
    int cycle_count = 0;

    // stimulus bookkeeping: which pointer entries hold a value, and whether
    // the queue is surely empty (after reset or clear, before any link)
    bit node_written [clq_pkg::NODE_COUNT];
    bit known_empty;
    int sent_by_op   [8];

    circular_linked_queue_manager i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    clq_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_owed         (owed),
        .o_fail_count   (fail_count),
        .o_checked      (checked),
        .o_empty_errors (empty_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers still owed", cycle_count, owed);
            $display("[circular_linked_queue_manager] ERROR");
            $finish;
        end
    end

    // result side: stall pattern independent of the sender
    initial begin
        int stretch;
        m_axis_tready <= 1'b0;
        forever begin
            case ($urandom_range(0, 3))
                0: begin
                    stretch = $urandom_range(5, 40);
                    repeat (stretch) @(posedge i_clk) m_axis_tready <= 1'b1;
                end
                1: begin
                    repeat (30) @(posedge i_clk) m_axis_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    stretch = $urandom_range(1, 20);
                    repeat (stretch) @(posedge i_clk) m_axis_tready <= 1'b0;
                    @(posedge i_clk) m_axis_tready <= 1'b1;
                end
                default: begin
                    repeat (16) @(posedge i_clk) m_axis_tready <= ~m_axis_tready;
                end
            endcase
        end
    end

    // present one request and hold it until accepted
    task automatic issue(input logic [clq_pkg::OPCODE_W-1:0] op,
                         input logic [clq_pkg::NODE_W-1:0]   node);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, node, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_by_op[op]++;
        if (op == clq_pkg::OP_INIT || op == clq_pkg::OP_PUSH || op == clq_pkg::OP_APPEND)
            node_written[node] = 1'b1;
        if (op == clq_pkg::OP_PUSH || op == clq_pkg::OP_APPEND) known_empty = 1'b0;
        if (op == clq_pkg::OP_CLEAR) known_empty = 1'b1;
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // hold off until every owed answer is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (owed != 0) @(posedge i_clk);
    endtask

    // random request; a link or successor request on an entry never written
    // turns into an init of that node unless the queue is surely empty
    task automatic pick_request(output logic [clq_pkg::OPCODE_W-1:0] op,
                                output logic [clq_pkg::NODE_W-1:0]   node);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)       op = clq_pkg::OP_CLEAR;
        else if (roll < 20) op = clq_pkg::OP_INIT;
        else if (roll < 35) op = clq_pkg::OP_PUSH;
        else if (roll < 50) op = clq_pkg::OP_APPEND;
        else if (roll < 65) op = clq_pkg::OP_POP;
        else if (roll < 73) op = clq_pkg::OP_ROTATE;
        else if (roll < 82) op = clq_pkg::OP_HEAD;
        else                op = clq_pkg::OP_SUCC;
        // mostly a small pool so nodes get relinked, sometimes any node
        if ($urandom_range(0, 9) < 7) node = 8'($urandom_range(0, 15));
        else                          node = 8'($urandom_range(0, clq_pkg::NODE_COUNT - 1));
        if ((op == clq_pkg::OP_PUSH || op == clq_pkg::OP_APPEND || op == clq_pkg::OP_SUCC)
                && !node_written[node] && !known_empty)
            op = clq_pkg::OP_INIT;
    endtask

    initial begin
        logic [clq_pkg::OPCODE_W-1:0] op;
        logic [clq_pkg::NODE_W-1:0]   node;
        int sent;
        int burst;

        known_empty = 1'b1;
        for (int k = 0; k < clq_pkg::NODE_COUNT; k++) node_written[k] = 1'b0;
        for (int k = 0; k < 8; k++) sent_by_op[k] = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-queue answers, singleton push and pop, then a
        // queue left behind by clear spliced into a new one by its node
        issue(clq_pkg::OP_POP,    8'h00);
        issue(clq_pkg::OP_SUCC,   8'hff);
        issue(clq_pkg::OP_ROTATE, 8'h00);
        issue(clq_pkg::OP_HEAD,   8'h00);
        issue(clq_pkg::OP_PUSH,   8'haa);   // unwritten node into an empty queue
        issue(clq_pkg::OP_HEAD,   8'h00);
        issue(clq_pkg::OP_SUCC,   8'haa);   // successor of the tail is null
        idle_gap($urandom_range(0, 3));
        issue(clq_pkg::OP_POP,    8'h00);   // last node leaves
        issue(clq_pkg::OP_INIT,   8'h00);
        issue(clq_pkg::OP_INIT,   8'hff);
        issue(clq_pkg::OP_APPEND, 8'h00);
        issue(clq_pkg::OP_APPEND, 8'hff);
        issue(clq_pkg::OP_INIT,   8'h55);
        issue(clq_pkg::OP_PUSH,   8'h55);
        idle_gap($urandom_range(0, 3));
        issue(clq_pkg::OP_ROTATE, 8'h00);
        issue(clq_pkg::OP_HEAD,   8'h00);
        issue(clq_pkg::OP_SUCC,   8'h00);
        issue(clq_pkg::OP_CLEAR,  8'h00);
        issue(clq_pkg::OP_INIT,   8'h33);
        issue(clq_pkg::OP_APPEND, 8'h33);
        issue(clq_pkg::OP_PUSH,   8'h00);   // brings in the whole old ring
        issue(clq_pkg::OP_HEAD,   8'h00);
        issue(clq_pkg::OP_POP,    8'h00);
        issue(clq_pkg::OP_SUCC,   8'hff);
        issue(clq_pkg::OP_ROTATE, 8'h00);
        drain();

        // random bursts with gaps; one full hold-off halfway through
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                pick_request(op, node);
                issue(op, node);
                sent++;
                if (sent == RANDOM_REQUESTS / 2) drain();
            end
            idle_gap($urandom_range(1, 12));
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests sent: clear %0d init %0d push %0d append %0d",
                 sent_by_op[clq_pkg::OP_CLEAR], sent_by_op[clq_pkg::OP_INIT],
                 sent_by_op[clq_pkg::OP_PUSH], sent_by_op[clq_pkg::OP_APPEND]);
        $display("               pop %0d rotate %0d head %0d succ %0d",
                 sent_by_op[clq_pkg::OP_POP], sent_by_op[clq_pkg::OP_ROTATE],
                 sent_by_op[clq_pkg::OP_HEAD], sent_by_op[clq_pkg::OP_SUCC]);
        $display("answers compared: %0d, empty-queue errors among them: %0d, mismatches: %0d",
                 checked, empty_errors, fail_count);
        if (fail_count == 0) begin
            $display("[circular_linked_queue_manager] OK");
        end else begin
            $display("[circular_linked_queue_manager] ERROR");
        end
        $finish;
    end

endmodule

@@ circular_linked_queue_manager.f @@
rtl/clq_pkg.sv
rtl/clq_ram.sv
rtl/clq_ctrl.sv
rtl/circular_linked_queue_manager.sv
tb/clq_checker.sv
tb/tb.sv
